// File: hw/rtl/egbl_pkg.sv
// Shared types and constants for the elevation grid bilinear lookup.
// Depends on nothing; every other RTL file of the block except egbl_ram imports it.
`default_nettype none

package egbl_pkg;

    // Grid geometry and fraction format
    localparam int GRID_SIZE  = 1201;
    localparam int FRAC_BITS  = 16;
    localparam int CELLS      = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int IDX_W      = $clog2(GRID_SIZE);
    localparam logic [31:0] CELLS_U = 32'(CELLS);

    // Port field widths
    localparam int LOAD_IDX_W = 21;
    localparam int IN_FRAC_W  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int HEIGHT_W   = 24;
    localparam int S_TDATA_W  = 72;

    // Arithmetic widths
    localparam int FIN_W      = (FRAC_BITS > IN_FRAC_W) ? FRAC_BITS : IN_FRAC_W;
    localparam int P_W        = FRAC_BITS + IDX_W;
    localparam int W_W        = FRAC_BITS + 1;
    localparam int PROD_W     = SAMPLE_W + FRAC_BITS + 1;
    localparam int TERM_W     = PROD_W + W_W;
    localparam int SHIFT      = 2 * FRAC_BITS - 8;

    localparam logic [W_W-1:0]           W_ONE      = W_W'(1) << FRAC_BITS;
    localparam logic signed [TERM_W-1:0] ROUND_HALF = TERM_W'(1) << (SHIFT - 1);
    localparam logic [SAMPLE_W-1:0]      VOID_RAW   = 16'h8000;

    // Result queue
    localparam int RES_DEPTH  = 4;
    localparam int RES_AW     = $clog2(RES_DEPTH);

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } egbl_req_t;

    // Item handed from the address front end to the memory sequencer.
    // addr is the load index for a load, the (row y, col x) base for a query.
    typedef struct packed {
        logic                 is_query;
        logic                 load_ok;
        logic [ADDR_W-1:0]    addr;
        logic [SAMPLE_W-1:0]  wdata;
        logic [FRAC_BITS-1:0] wy;
        logic [FRAC_BITS-1:0] wx;
    } egbl_item_t;

    // Tag that travels with each grid read, aligned with the RAM read data.
    typedef struct packed {
        logic           valid;
        logic [1:0]     k;
        logic [W_W-1:0] wy_sel;
        logic [W_W-1:0] wx_sel;
    } egbl_tag_t;

    typedef struct packed {
        logic                void_found;
        logic [HEIGHT_W-1:0] height_q8;
    } egbl_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/egbl_ram.sv
// Generic single-port synchronous RAM, one access per cycle, registered read.
// No dependencies; read data holds while the port is not enabled.
`default_nettype none

module egbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/egbl_front.sv
// Address front end: fraction scaling, then flipped-row base address.
// Depends on egbl_pkg. Two stall-able pipeline stages.
`default_nettype none

module egbl_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             req_type,
    input  wire logic [egbl_pkg::LOAD_IDX_W-1:0]  load_index,
    input  wire logic [7:0]                       byte_hi,
    input  wire logic [7:0]                       byte_lo,
    input  wire logic [egbl_pkg::IN_FRAC_W-1:0]   lat_frac,
    input  wire logic [egbl_pkg::IN_FRAC_W-1:0]   lon_frac,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output egbl_pkg::egbl_item_t                  out_item
);

    import egbl_pkg::*;

    // stage A: fractions scaled by GRID_SIZE-1
    logic                 a_valid_reg;
    logic                 a_query_reg;
    logic                 a_load_ok_reg;
    logic [ADDR_W-1:0]    a_idx_reg;
    logic [SAMPLE_W-1:0]  a_wdata_reg;
    logic [IDX_W-1:0]     a_y_reg;
    logic [IDX_W-1:0]     a_x_reg;
    logic [FRAC_BITS-1:0] a_wy_reg;
    logic [FRAC_BITS-1:0] a_wx_reg;

    // stage B: item for the sequencer
    logic                 b_valid_reg;
    egbl_item_t           b_item_reg;

    logic                 a_ready;
    logic                 b_ready;
    logic                 a_take;
    logic                 b_take;
    logic [FRAC_BITS-1:0] lat_w;
    logic [FRAC_BITS-1:0] lon_w;
    logic [P_W-1:0]       py;
    logic [P_W-1:0]       px;
    logic [IDX_W-1:0]     row;
    logic [ADDR_W-1:0]    base;
    egbl_item_t           b_item_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign a_take   = in_valid && a_ready;
    assign b_take   = a_valid_reg && b_ready;

    assign lat_w = FRAC_BITS'(FIN_W'(lat_frac));
    assign lon_w = FRAC_BITS'(FIN_W'(lon_frac));
    assign py    = P_W'(lat_w) * P_W'(GRID_SIZE - 1);
    assign px    = P_W'(lon_w) * P_W'(GRID_SIZE - 1);

    // row counts from the bottom edge in the query, from the top in memory
    assign row  = IDX_W'(GRID_SIZE - 1) - a_y_reg;
    assign base = ADDR_W'(row) * ADDR_W'(GRID_SIZE) + ADDR_W'(a_x_reg);

    always_comb
    begin
        b_item_next.is_query = a_query_reg;
        b_item_next.load_ok  = a_load_ok_reg;
        b_item_next.addr     = a_query_reg ? base : a_idx_reg;
        b_item_next.wdata    = a_wdata_reg;
        b_item_next.wy       = a_wy_reg;
        b_item_next.wx       = a_wx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            a_query_reg   <= (egbl_req_t'(req_type) == REQ_QUERY);
            a_load_ok_reg <= (32'(load_index) < CELLS_U);
            a_idx_reg     <= ADDR_W'(load_index);
            a_wdata_reg   <= {byte_hi, byte_lo};
            a_y_reg       <= py[P_W-1:FRAC_BITS];
            a_wy_reg      <= py[FRAC_BITS-1:0];
            a_x_reg       <= px[P_W-1:FRAC_BITS];
            a_wx_reg      <= px[FRAC_BITS-1:0];
        end
        if (b_take)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

`default_nettype wire

// File: hw/rtl/egbl_seq.sv
// Memory sequencer: owns the single grid RAM port, one write per in-range
// load, four reads per query. Depends on egbl_pkg and egbl_ram.
`default_nettype none

module egbl_seq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire egbl_pkg::egbl_item_t           in_item,
    input  wire logic                           credit_ok,
    output logic                                credit_take,
    output egbl_pkg::egbl_tag_t                 tag,
    output logic [egbl_pkg::SAMPLE_W-1:0]       rdata
);

    import egbl_pkg::*;

    logic              c_valid_reg;
    logic              c_valid_next;
    egbl_item_t        c_item_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    egbl_tag_t         tag_reg;
    egbl_tag_t         tag_next;

    logic              go;
    logic              done;
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;

    // read order: (y,x) (y+1,x) (y,x+1) (y+1,x+1); row y+1 sits one row up
    assign go = c_valid_reg && c_item_reg.is_query && ((cnt_reg != 2'd0) || credit_ok);

    always_comb
    begin
        if (c_item_reg.is_query)
        begin
            done     = go && (cnt_reg == 2'd3);
            ram_en   = go;
            ram_we   = 1'b0;
            ram_addr = c_item_reg.addr + ADDR_W'(cnt_reg[1])
                       - (cnt_reg[0] ? ADDR_W'(GRID_SIZE) : ADDR_W'(0));
        end
        else
        begin
            done     = c_valid_reg;
            ram_en   = c_valid_reg && c_item_reg.load_ok;
            ram_we   = 1'b1;
            ram_addr = c_item_reg.addr;
        end
    end

    assign in_ready    = !c_valid_reg || done;
    assign credit_take = go && (cnt_reg == 2'd0);
    assign cnt_next    = go ? (cnt_reg + 2'd1) : cnt_reg;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            c_valid_next = 1'b1;
        end
        else if (done)
        begin
            c_valid_next = 1'b0;
        end
        else
        begin
            c_valid_next = c_valid_reg;
        end
    end

    always_comb
    begin
        tag_next.valid  = go;
        tag_next.k      = cnt_reg;
        tag_next.wy_sel = cnt_reg[0] ? W_W'(c_item_reg.wy) : (W_ONE - W_W'(c_item_reg.wy));
        tag_next.wx_sel = cnt_reg[1] ? W_W'(c_item_reg.wx) : (W_ONE - W_W'(c_item_reg.wx));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            cnt_reg     <= 2'd0;
            tag_reg     <= '0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            cnt_reg     <= cnt_next;
            tag_reg     <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            c_item_reg <= in_item;
        end
    end

    egbl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (c_item_reg.wdata),
        .rdata (rdata)
    );

    assign tag = tag_reg;

endmodule

`default_nettype wire

// File: hw/rtl/egbl_blend.sv
// Bilinear blend: per-sample weight multiply, column sums, column weight
// multiply, final sum with rounding. Depends on egbl_pkg. Never stalls.
`default_nettype none

module egbl_blend (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire egbl_pkg::egbl_tag_t        tag,
    input  wire logic [egbl_pkg::SAMPLE_W-1:0] rdata,
    output logic                            res_valid,
    output egbl_pkg::egbl_res_t             res
);

    import egbl_pkg::*;

    // M1: sample times row weight
    logic                     m1_valid_reg;
    logic [1:0]               m1_k_reg;
    logic [W_W-1:0]           m1_wx_reg;
    logic                     m1_void_reg;
    logic signed [PROD_W-1:0] m1_prod_reg;

    // M2: column sum
    logic signed [PROD_W-1:0] part_reg;
    logic                     part_void_reg;
    logic                     col_valid_reg;
    logic                     col_second_reg;
    logic                     col_void_reg;
    logic [W_W-1:0]           col_wx_reg;
    logic signed [PROD_W-1:0] col_reg;

    // M3: column times column weight
    logic                     t_valid_reg;
    logic                     t_second_reg;
    logic                     t_void_reg;
    logic signed [TERM_W-1:0] term_reg;

    // M4: final sum
    logic signed [TERM_W-1:0] sum_part_reg;
    logic                     sum_void_reg;
    logic                     res_valid_reg;
    egbl_res_t                res_reg;

    logic signed [PROD_W-1:0] h_ext;
    logic signed [PROD_W-1:0] wy_ext;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [TERM_W-1:0] c_ext;
    logic signed [TERM_W-1:0] wx_ext;
    logic signed [TERM_W-1:0] term_next;
    logic signed [TERM_W-1:0] total;
    logic                     void_all;

    assign h_ext     = PROD_W'($signed(rdata));
    assign wy_ext    = $signed(PROD_W'(tag.wy_sel));
    assign prod_next = h_ext * wy_ext;

    assign c_ext     = TERM_W'(col_reg);
    assign wx_ext    = $signed(TERM_W'(col_wx_reg));
    assign term_next = c_ext * wx_ext;

    // floor((sum + half) / 2^SHIFT): round to nearest, ties up
    assign total    = sum_part_reg + term_reg + ROUND_HALF;
    assign void_all = sum_void_reg || t_void_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            col_valid_reg <= 1'b0;
            t_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg  <= tag.valid;
            col_valid_reg <= m1_valid_reg && m1_k_reg[0];
            t_valid_reg   <= col_valid_reg;
            res_valid_reg <= t_valid_reg && t_second_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_k_reg    <= tag.k;
        m1_wx_reg   <= tag.wx_sel;
        m1_void_reg <= (rdata == VOID_RAW);
        m1_prod_reg <= prod_next;

        if (m1_valid_reg && !m1_k_reg[0])
        begin
            part_reg      <= m1_prod_reg;
            part_void_reg <= m1_void_reg;
        end
        col_reg        <= part_reg + m1_prod_reg;
        col_void_reg   <= part_void_reg || m1_void_reg;
        col_second_reg <= m1_k_reg[1];
        col_wx_reg     <= m1_wx_reg;

        term_reg     <= term_next;
        t_second_reg <= col_second_reg;
        t_void_reg   <= col_void_reg;

        if (t_valid_reg && !t_second_reg)
        begin
            sum_part_reg <= term_reg;
            sum_void_reg <= t_void_reg;
        end
        res_reg.void_found <= void_all;
        res_reg.height_q8  <= void_all ? HEIGHT_W'(0) : total[SHIFT +: HEIGHT_W];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/elevation_grid_bilinear_lookup.sv
// Top level of the elevation grid bilinear lookup: stream ports, result queue.
// Depends on egbl_pkg, egbl_front, egbl_seq (with egbl_ram) and egbl_blend.
//
//  channel   | dir | tdata                                  | tuser
//  ----------+-----+----------------------------------------+-------------------
//  s_ (in)   | in  | load_index, byte_hi, byte_lo, lat, lon | req_type 0=ld 1=q
//  m_ (out)  | out | height_q8 (signed, 1/256 m)            | void_found
//
// A load transaction holds the single grid RAM port for one write, a query
// for its four neighbor reads, so loads sustain one per cycle unless a query
// ahead holds the port or waits for a result credit. The grid has no reset
// and no clearing pass: entries are undefined until loaded. A four-entry
// result queue with credit tracking parts the output from the core; a stalled
// m_ side stops new query reads only once four results are outstanding.
`default_nettype none

module elevation_grid_bilinear_lookup (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [20:0] load_index, [28:21] byte_hi, [36:29] byte_lo,
    // [52:37] lat_frac, [68:53] lon_frac, [71:69] zero
    input  wire logic [egbl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [23:0] height_q8
    output logic [egbl_pkg::HEIGHT_W-1:0]        m_tdata,
    // [0] void_found
    output logic                                 m_tuser
);

    import egbl_pkg::*;

    logic       f_valid;
    logic       f_ready;
    egbl_item_t f_item;
    logic       credit_ok;
    logic       credit_take;
    egbl_tag_t  tag;
    logic [SAMPLE_W-1:0] rdata;
    logic       res_valid;
    egbl_res_t  res;

    egbl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .load_index (s_tdata[20:0]),
        .byte_hi    (s_tdata[28:21]),
        .byte_lo    (s_tdata[36:29]),
        .lat_frac   (s_tdata[52:37]),
        .lon_frac   (s_tdata[68:53]),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_item   (f_item)
    );

    // Loads and queries reach the RAM port in arrival order, so a query
    // always sees every earlier load; no forwarding is needed.
    egbl_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (f_valid),
        .in_ready    (f_ready),
        .in_item     (f_item),
        .credit_ok   (credit_ok),
        .credit_take (credit_take),
        .tag         (tag),
        .rdata       (rdata)
    );

    egbl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue. A credit is taken when a query starts its reads and
    // returned when its result leaves, so the queue can never overflow.
    egbl_res_t         fifo_reg [RES_DEPTH];
    logic [RES_AW-1:0] wr_ptr_reg;
    logic [RES_AW-1:0] rd_ptr_reg;
    logic [RES_AW:0]   cnt_reg;
    logic [RES_AW:0]   cnt_next;
    logic [RES_AW:0]   cred_reg;
    logic [RES_AW:0]   cred_next;
    logic              push;
    logic              pop;

    assign push      = res_valid;
    assign pop       = m_tvalid && m_tready;
    assign credit_ok = (cred_reg < (RES_AW + 1)'(RES_DEPTH));
    assign cnt_next  = cnt_reg + (RES_AW + 1)'(push) - (RES_AW + 1)'(pop);
    assign cred_next = cred_reg + (RES_AW + 1)'(credit_take) - (RES_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            cred_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + RES_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_AW'(1);
            end
            cnt_reg  <= cnt_next;
            cred_reg <= cred_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = fifo_reg[rd_ptr_reg].height_q8;
    assign m_tuser  = fifo_reg[rd_ptr_reg].void_found;

    // Credits bound the queries in flight plus the results queued.
    a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cred_reg <= (RES_AW + 1)'(RES_DEPTH))
        else $error("result credits exceed queue depth");

    a_cred_covers: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cred_reg)
        else $error("queued results without credits");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((cnt_reg != (RES_AW + 1)'(RES_DEPTH)) || pop))
        else $error("result queue overflow");

    a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
        credit_take |-> credit_ok)
        else $error("query started without a free credit");

endmodule

`default_nettype wire

// File: tb/elevation_grid_bilinear_lookup_test.sv
// Self-checking testbench for elevation_grid_bilinear_lookup: loads grid samples,
// queries bilinear heights and checks every result against a local predictor.
// Depends on egbl_pkg and the RTL of the block; reads no files.
`default_nettype none

module elevation_grid_bilinear_lookup_test;
    import egbl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 680;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_LOAD_IDX = (1 << LOAD_IDX_W) - 1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [HEIGHT_W-1:0]  m_tdata;
    logic                 m_tuser;

    // Predictor state: grid contents as written so far (sparse)
    logic [SAMPLE_W-1:0] grid_mem [int];
    egbl_res_t           expected_heights [$];
    int                  recent_y [$];
    int                  recent_x [$];

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int snk_hold_len = 0;

    int fail_count = 0;
    int n_loads = 0;
    int n_ignored = 0;
    int n_queries = 0;
    int n_void = 0;
    int n_checked = 0;
    int cycle_count = 0;

    elevation_grid_bilinear_lookup u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic int grid_addr(int y, int x);
        // rows count from the bottom edge, storage from the top
        return (GRID_SIZE - 1 - y) * GRID_SIZE + x;
    endfunction

    function automatic longint grid_sample(int y, int x, inout bit is_void);
        logic [SAMPLE_W-1:0] raw;
        raw = grid_mem.exists(grid_addr(y, x)) ? grid_mem[grid_addr(y, x)] : '0;
        if (raw == VOID_RAW)
            is_void = 1'b1;
        return longint'($signed(raw));
    endfunction

    function automatic egbl_res_t blend_height(logic [15:0] lat, logic [15:0] lon);
        longint    one;
        longint    py;
        longint    px;
        longint    wy;
        longint    wx;
        int        y;
        int        x;
        longint    h00;
        longint    h01;
        longint    h10;
        longint    h11;
        longint    acc;
        bit        is_void;
        egbl_res_t res;
        one = longint'(1) << FRAC_BITS;
        py  = longint'(lat) * (GRID_SIZE - 1);
        px  = longint'(lon) * (GRID_SIZE - 1);
        y   = int'(py >> FRAC_BITS);
        x   = int'(px >> FRAC_BITS);
        wy  = py & (one - 1);
        wx  = px & (one - 1);
        is_void = 1'b0;
        h00 = grid_sample(y, x, is_void);
        h01 = grid_sample(y, x + 1, is_void);
        h10 = grid_sample(y + 1, x, is_void);
        h11 = grid_sample(y + 1, x + 1, is_void);
        res.void_found = is_void;
        if (is_void)
        begin
            res.height_q8 = '0;
        end
        else
        begin
            acc = h00 * ((one - wy) * (one - wx)) + h01 * ((one - wy) * wx)
                + h10 * (wy * (one - wx)) + h11 * (wy * wx);
            // round half up: add half an LSB, then floor
            acc = (acc + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
            res.height_q8 = acc[HEIGHT_W-1:0];
        end
        return res;
    endfunction

    // Random fraction that lands on pixel index i
    function automatic logic [15:0] frac_for_index(int i);
        longint lo;
        longint hi;
        lo = (longint'(i) * 65536 + GRID_SIZE - 2) / (GRID_SIZE - 1);
        hi = (longint'(i + 1) * 65536 + GRID_SIZE - 2) / (GRID_SIZE - 1) - 1;
        if (hi > 65535)
            hi = 65535;
        return 16'($urandom_range(int'(hi), int'(lo)));
    endfunction

    function automatic logic [15:0] rand_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return VOID_RAW;
        if (r < 16)
        begin
            case ($urandom_range(0, 5))
                0:       return 16'h7FFF;
                1:       return 16'h8001;
                2:       return 16'hFFFF;
                3:       return 16'h0000;
                4:       return 16'h0080;
                default: return 16'hFF7F;
            endcase
        end
        return 16'($urandom);
    endfunction

    // One input transaction; the prediction is made at acceptance
    task automatic send_item(egbl_req_t kind, logic [20:0] idx, logic [15:0] value,
                             logic [15:0] lat, logic [15:0] lon);
        int        gap;
        egbl_res_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, lon, lat, value[7:0], value[15:8], idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == REQ_QUERY)
        begin
            res = blend_height(lat, lon);
            expected_heights.push_back(res);
            n_queries++;
            if (res.void_found)
                n_void++;
        end
        else if (idx < CELLS)
        begin
            grid_mem[int'(idx)] = value;
            n_loads++;
        end
        else
        begin
            n_ignored++;
        end
        gap = src_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Query fields of a load and load fields of a query carry junk
    task automatic send_load(int idx, logic [15:0] value);
        send_item(REQ_LOAD, 21'(idx), value, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(logic [15:0] lat, logic [15:0] lon);
        send_item(REQ_QUERY, 21'($urandom), 16'($urandom), lat, lon);
    endtask

    task automatic load_pixel(int y, int x, logic [15:0] value);
        send_load(grid_addr(y, x), value);
    endtask

    // Make sure all four neighbors of (y, x) hold a value
    task automatic prepare_pixel(int y, int x);
        int dy;
        int dx;
        for (dy = 0; dy < 2; dy++)
            for (dx = 0; dx < 2; dx++)
                if (!grid_mem.exists(grid_addr(y + dy, x + dx)))
                    load_pixel(y + dy, x + dx, rand_height());
    endtask

    task automatic test_corner_pixels();
        // bottom-left cell: zero and maximum weights, low byte with bit 7 set
        load_pixel(0, 0, 16'h7FFF);
        load_pixel(0, 1, 16'h8001);
        load_pixel(1, 0, 16'h0080);
        load_pixel(1, 1, 16'hFFFF);
        send_query(16'd0, 16'd0);
        send_query(16'd54, 16'd54);
        send_query(16'd0, 16'd54);
        // top-right cell: all-ones fractions reach the last row and column
        load_pixel(1199, 1199, 16'h8001);
        load_pixel(1199, 1200, 16'h7FFF);
        load_pixel(1200, 1199, 16'hFF7F);
        load_pixel(1200, 1200, 16'h0100);
        send_query(16'hFFFF, 16'hFFFF);
        // lowest latitude fraction that still lands on the last pixel row
        send_query(16'd65482, 16'hFFFF);
    endtask

    task automatic test_void_and_ignored_loads();
        // void sample flags the result even under a zero weight
        load_pixel(0, 1, VOID_RAW);
        send_query(16'd0, 16'd0);
        // loads past the grid end change nothing
        send_load(CELLS, 16'h1234);
        send_load(MAX_LOAD_IDX, VOID_RAW);
        load_pixel(0, 1, 16'h1234);
        send_query(16'd0, 16'd0);
        send_query(16'd27, 16'd40);
    endtask

    task automatic test_output_backpressure();
        int i;
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        snk_hold_len = 300;
        for (i = 0; i < 24; i++)
        begin
            if (i[0])
                send_query(frac_for_index(0), frac_for_index(0));
            else
                send_query(frac_for_index(1199), frac_for_index(1199));
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start;
        int r;
        int k;
        int y;
        int x;
        logic [15:0] lat;
        logic [15:0] lon;
        start = n_loads + n_queries;
        while (n_loads + n_queries - start < RANDOM_ITEMS)
        begin
            // rotate idling so there are stretches with and without gaps
            k = ((n_loads + n_queries - start) / 100) % 4;
            src_idle_on = (k != 1) && (k != 3);
            snk_idle_on = (k != 2) && (k != 3);
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_load($urandom_range(0, MAX_LOAD_IDX), rand_height());
            end
            else if (r < 25 && recent_y.size() != 0)
            begin
                k = $urandom_range(0, recent_y.size() - 1);
                load_pixel(recent_y[k] + $urandom_range(0, 1),
                           recent_x[k] + $urandom_range(0, 1), rand_height());
            end
            else
            begin
                if (recent_y.size() != 0 && $urandom_range(0, 1))
                begin
                    k = $urandom_range(0, recent_y.size() - 1);
                    lat = frac_for_index(recent_y[k]);
                    lon = frac_for_index(recent_x[k]);
                end
                else
                begin
                    lat = 16'($urandom);
                    lon = 16'($urandom);
                end
                y = int'((longint'(lat) * (GRID_SIZE - 1)) >> FRAC_BITS);
                x = int'((longint'(lon) * (GRID_SIZE - 1)) >> FRAC_BITS);
                prepare_pixel(y, x);
                send_query(lat, lon);
                recent_y.push_back(y);
                recent_x.push_back(x);
                if (recent_y.size() > 64)
                begin
                    void'(recent_y.pop_front());
                    void'(recent_x.pop_front());
                end
            end
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    // Result receiver: random stall before each result, or one long hold
    initial
    begin : receiver
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = snk_idle_on ? $urandom_range(0, 9) : 0;
            if (snk_hold_len != 0)
            begin
                gap = snk_hold_len;
                snk_hold_len = 0;
            end
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Compare each result with the oldest outstanding query
    always @(posedge clk)
    begin : result_check
        egbl_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_heights.size() == 0)
            begin
                $error("result with no query outstanding: height_q8 %0d void_found %0b",
                       $signed(m_tdata), m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_heights.pop_front();
                n_checked++;
                if (m_tdata !== want.height_q8)
                begin
                    $error("height_q8 mismatch: expected %0d, actual %0d",
                           $signed(want.height_q8), $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser !== want.void_found)
                begin
                    $error("void_found mismatch: expected %0b, actual %0b",
                           want.void_found, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_heights.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : main
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_pixels();
        test_void_and_ignored_loads();
        test_output_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_heights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d grid loads, %0d out-of-range loads, %0d height queries",
                 n_loads, n_ignored, n_queries);
        $display("(%0d void), %0d results checked, including a long output hold.",
                 n_void, n_checked);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
